// File: hdl/bfcp_attribute_tlv_parser_macros.svh
// Assertion macros shared by the attribute parser modules.
`ifndef BFCP_ATTRIBUTE_TLV_PARSER_MACROS_SVH
`define BFCP_ATTRIBUTE_TLV_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bfcp_pkg.sv
// Types and constants of the attribute parser.
package bfcp_pkg;

    localparam logic [7:0] HEADER_OCTETS = 8'd2;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_CONTENT = 2'd2,
        PH_PAD     = 2'd3
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [6:0] attr_type;
        logic       mandatory_bit;
        logic [7:0] content_byte;
        logic       content_valid;
        logic       attr_last;
        logic       message_done;
        logic       malformed;
    } t_result;

endpackage

// File: hdl/bfcp_core.sv
// Attribute walk state machine: phase, held header and counters, one octet per fire.
module bfcp_core
    import bfcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    output t_result    o_res
);

`include "bfcp_attribute_tlv_parser_macros.svh"

    t_phase     r_phase,   n_phase;
    logic [6:0] r_type,    n_type;
    logic       r_mand,    n_mand;
    logic [7:0] r_content, n_content;
    logic [1:0] r_pad,     n_pad;
    logic       r_fault,   n_fault;

    logic       short_len;
    logic       last_content;

    assign short_len    = (i_byte < HEADER_OCTETS);
    assign last_content = (r_content == 8'd1);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_mand    = r_mand;
        n_content = r_content;
        n_pad     = r_pad;
        n_fault   = r_fault;
        if (r_fault) begin
            if (i_eom) begin
                n_phase = PH_TYPE;
                n_fault = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = i_byte[7:1];
                    n_mand  = i_byte[0];
                    n_phase = i_eom ? PH_TYPE : PH_LEN;
                end
                PH_LEN: begin
                    if (short_len) begin
                        if (i_eom) n_phase = PH_TYPE;
                        else       n_fault = 1'b1;
                    end else begin
                        n_content = i_byte - HEADER_OCTETS;
                        n_pad     = 2'b00 - i_byte[1:0];
                        if (i_eom)                      n_phase = PH_TYPE;
                        else if (n_content == 8'd0)     n_phase = (n_pad != 2'd0) ? PH_PAD
                                                                                  : PH_TYPE;
                        else                            n_phase = PH_CONTENT;
                    end
                end
                PH_CONTENT: begin
                    n_content = r_content - 8'd1;
                    if (i_eom)             n_phase = PH_TYPE;
                    else if (last_content) n_phase = (r_pad != 2'd0) ? PH_PAD : PH_TYPE;
                end
                PH_PAD: begin
                    n_pad = r_pad - 2'd1;
                    if (i_eom || n_pad == 2'd0) n_phase = PH_TYPE;
                end
                default: n_phase = PH_TYPE;
            endcase
        end
    end

    // result of this octet
    always_comb begin
        o_res               = '0;
        o_res.attr_type     = n_type;
        o_res.mandatory_bit = n_mand;
        if (!r_fault) begin
            unique case (r_phase)
                PH_TYPE: begin
                    o_res.emit      = i_eom;
                    o_res.malformed = 1'b1;
                end
                PH_LEN: begin
                    if (short_len || i_eom) begin
                        o_res.emit      = 1'b1;
                        o_res.malformed = 1'b1;
                    end else if (n_content == 8'd0) begin
                        o_res.emit      = 1'b1;
                        o_res.attr_last = 1'b1;
                    end
                end
                PH_CONTENT: begin
                    o_res.emit          = 1'b1;
                    o_res.content_byte  = i_byte;
                    o_res.content_valid = 1'b1;
                    o_res.attr_last     = last_content;
                    if (i_eom) begin
                        o_res.message_done = last_content && (r_pad == 2'd0);
                        o_res.malformed    = !(last_content && (r_pad == 2'd0));
                    end
                end
                PH_PAD: begin
                    if (i_eom) begin
                        o_res.emit         = 1'b1;
                        o_res.message_done = (n_pad == 2'd0);
                        o_res.malformed    = (n_pad != 2'd0);
                    end
                end
                default: o_res.emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_type    <= '0;
            r_mand    <= 1'b0;
            r_content <= '0;
            r_pad     <= '0;
            r_fault   <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_mand    <= n_mand;
            r_content <= n_content;
            r_pad     <= n_pad;
            r_fault   <= n_fault;
        end
    end

    `BFCP_ASSERT_NEXT(a_eom_restarts, i_clk, i_rst_n, i_fire && i_eom,
        r_phase == PH_TYPE && !r_fault, "end of message did not restart the parser")
    `BFCP_ASSERT_IMPLY(a_fault_in_len, i_clk, i_rst_n, r_fault,
        r_phase == PH_LEN, "fault flag set outside the length phase")
    `BFCP_ASSERT_IMPLY(a_content_nonzero, i_clk, i_rst_n, r_phase == PH_CONTENT && !r_fault,
        r_content != 8'd0, "contents phase with no content left")

endmodule

// File: hdl/bfcp_attribute_tlv_parser.sv
// Top level of the BFCP attribute parser: input register, parser core, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  octets  | in        | i_valid / o_stall    | i_data_byte, i_end_of_message
//  results | out       | o_valid / i_stall    | o_attr_type ... o_malformed
//
//  One octet per cycle while i_stall is low; a result is registered when its octet is processed.
//  The rate is set by the single pass through the phase logic of bfcp_core.
//  Synchronous active-low reset clears phase, counters, fault flag and valid bits.
//  A stalled result holds in the output register; the queued octet is processed
//  in the cycle the result is taken, so o_stall rises only while both stages hold.
module bfcp_attribute_tlv_parser
    import bfcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_attr_type,
    output logic       o_mandatory_bit,
    output logic [7:0] o_content_byte,
    output logic       o_content_valid,
    output logic       o_attr_last,
    output logic       o_message_done,
    output logic       o_malformed
);

`include "bfcp_attribute_tlv_parser_macros.svh"

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eom;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;   // result slot free or emptied this cycle
    logic       fire;      // queued octet goes through the parser
    logic       accept;
    t_result    core_res;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eom  <= i_end_of_message;
        end
    end

    bfcp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eom   (r_in_eom),
        .o_res   (core_res)
    );

    // an octet without a result simply empties the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && core_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_res.emit) begin
            r_out <= core_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_attr_type     = r_out.attr_type;
    assign o_mandatory_bit = r_out.mandatory_bit;
    assign o_content_byte  = r_out.content_byte;
    assign o_content_valid = r_out.content_valid;
    assign o_attr_last     = r_out.attr_last;
    assign o_message_done  = r_out.message_done;
    assign o_malformed     = r_out.malformed;

    `BFCP_ASSERT_IMPLY(a_done_xor_bad, i_clk, i_rst_n, o_valid,
        !(o_message_done && o_malformed), "result both done and malformed")
    `BFCP_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, o_valid && o_content_valid && o_message_done,
        o_attr_last, "clean end on a content octet that is not the last")
    `BFCP_ASSERT_IMPLY(a_marker_clean, i_clk, i_rst_n,
        o_valid && !o_content_valid && o_attr_last,
        !o_malformed && !o_message_done, "empty attribute marker carries a status flag")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the BFCP attribute TLV parser.
module tb;
    import bfcp_pkg::*;

    // Mirrors the parser's walk over the attribute area and keeps the results
    // that each accepted octet should produce, oldest first.
    class attr_tracker;
        t_phase      phase;
        logic [6:0]  held_type;
        logic        held_mand;
        logic [7:0]  content_left;
        logic [1:0]  padding_left;
        logic        fault_seen;
        t_result     pending_results[$];
        int unsigned errors;

        function new();
            phase        = PH_TYPE;
            held_type    = '0;
            held_mand    = 1'b0;
            content_left = '0;
            padding_left = '0;
            fault_seen   = 1'b0;
            errors       = 0;
        endfunction

        function void queue_result(logic [7:0] octet, logic valid, logic is_last,
                                   logic done, logic bad);
            t_result r;
            r.emit          = 1'b1;
            r.attr_type     = held_type;
            r.mandatory_bit = held_mand;
            r.content_byte  = octet;
            r.content_valid = valid;
            r.attr_last     = is_last;
            r.message_done  = done;
            r.malformed     = bad;
            pending_results.push_back(r);
        endfunction

        function void note_octet(logic [7:0] octet, logic eom);
            logic is_last;
            logic clean;
            // after a fault only the end of message matters
            if (fault_seen) begin
                if (eom) begin
                    phase      = PH_TYPE;
                    fault_seen = 1'b0;
                end
                return;
            end
            case (phase)
                PH_TYPE: begin
                    held_type = octet[7:1];
                    held_mand = octet[0];
                    if (eom) begin
                        queue_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                        phase = PH_TYPE;
                    end else begin
                        phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (octet < HEADER_OCTETS) begin
                        queue_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                        if (eom) phase = PH_TYPE;
                        else fault_seen = 1'b1;
                    end else begin
                        content_left = octet - HEADER_OCTETS;
                        padding_left = 2'd0 - octet[1:0];
                        if (eom) begin
                            queue_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                            phase = PH_TYPE;
                        end else if (content_left == 0) begin
                            queue_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                            phase = (padding_left != 0) ? PH_PAD : PH_TYPE;
                        end else begin
                            phase = PH_CONTENT;
                        end
                    end
                end
                PH_CONTENT: begin
                    content_left = content_left - 8'd1;
                    is_last = (content_left == 0);
                    if (is_last) phase = (padding_left != 0) ? PH_PAD : PH_TYPE;
                    if (eom) begin
                        clean = is_last && (padding_left == 0);
                        queue_result(octet, 1'b1, is_last, clean, !clean);
                        phase = PH_TYPE;
                    end else begin
                        queue_result(octet, 1'b1, is_last, 1'b0, 1'b0);
                    end
                end
                default: begin
                    padding_left = padding_left - 2'd1;
                    if (padding_left == 0) phase = PH_TYPE;
                    if (eom) begin
                        clean = (padding_left == 0);
                        queue_result(8'h00, 1'b0, 1'b0, clean, !clean);
                        phase = PH_TYPE;
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("attr_type",     want.attr_type,     got.attr_type);
            compare_field("mandatory_bit", want.mandatory_bit, got.mandatory_bit);
            compare_field("content_byte",  want.content_byte,  got.content_byte);
            compare_field("content_valid", want.content_valid, got.content_valid);
            compare_field("attr_last",     want.attr_last,     got.attr_last);
            compare_field("message_done",  want.message_done,  got.message_done);
            compare_field("malformed",     want.malformed,     got.malformed);
        endfunction
    endclass

    // Watchdog limit in cycles without any transaction on either side; the
    // longest legitimate quiet spell is the receiver hold-off plus a few stalls.
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned OCTET_TARGET  = 450;
    localparam int unsigned IDLE_PERCENT  = 18;
    localparam int unsigned HOLD_OFF_LEN  = 48;
    localparam int unsigned HOLD_OFF_AT   = 40;
    // window of transactions with no idling on the respective side
    localparam int unsigned BURST_FROM    = 150;
    localparam int unsigned BURST_TO      = 260;

    logic       i_clk;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic [7:0] i_data_byte      = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       i_stall          = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_attr_type;
    logic       o_mandatory_bit;
    logic [7:0] o_content_byte;
    logic       o_content_valid;
    logic       o_attr_last;
    logic       o_message_done;
    logic       o_malformed;

    attr_tracker tracker = new();
    logic [7:0]  msg_q[$];
    int unsigned octets_taken  = 0;
    int unsigned results_taken = 0;
    bit          hold_busy     = 1'b0;

    bfcp_attribute_tlv_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_attr_type      (o_attr_type),
        .o_mandatory_bit  (o_mandatory_bit),
        .o_content_byte   (o_content_byte),
        .o_content_valid  (o_content_valid),
        .o_attr_last      (o_attr_last),
        .o_message_done   (o_message_done),
        .o_malformed      (o_malformed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one octet, idling at random beforehand except during the burst
    // window and the receiver hold-off (so the block really does back up).
    task automatic send_octet(input logic [7:0] octet, input logic eom);
        while (!hold_busy && !(octets_taken >= BURST_FROM && octets_taken < BURST_TO)
               && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid          <= 1'b0;
            i_data_byte      <= 8'($urandom_range(0, 255));
            i_end_of_message <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= octet;
        i_end_of_message <= eom;
        // outputs are sampled before this edge's updates land
        do @(posedge i_clk); while (o_stall);
        tracker.note_octet(octet, eom);
        octets_taken++;
    endtask

    // Send msg_q as one message, end-of-message flag on its last octet.
    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_octet(msg_q[i], i == msg_q.size() - 1);
    endtask

    // Stimulus: directed messages, then mostly well-formed random messages
    // with a share of truncated, corrupted and pure-noise ones.
    initial begin : stimulus
        logic [7:0]  hdr;
        logic [7:0]  len;
        int unsigned n_attr;
        int unsigned kind;
        int unsigned cut;
        int unsigned pad;
        int unsigned msg_count;
        int unsigned len_pos[$];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // top type with mandatory flag, three contents, three padding octets
        msg_q = '{8'hFF, 8'h05, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'h00};
        send_message();
        // empty attribute with non-zero padding, then an unpadded one ending cleanly
        msg_q = '{8'h00, 8'h02, 8'hFF, 8'hFF, 8'h03, 8'h04, 8'hC3, 8'h3C};
        send_message();
        // zero length: fault, remainder of the message ignored
        msg_q = '{8'h10, 8'h00, 8'h33, 8'h44};
        send_message();
        // length one on the final octet
        msg_q = '{8'h0F, 8'h01};
        send_message();
        // message ends inside the header
        msg_q = '{8'hAA};
        send_message();
        // empty attribute closing the message: padding missing
        msg_q = '{8'h08, 8'h02};
        send_message();
        // message ends mid-contents
        msg_q = '{8'h05, 8'hFF, 8'h81};
        send_message();
        // last content octet arrives but padding is still owed
        msg_q = '{8'h09, 8'h03, 8'h77};
        send_message();

        msg_count = 0;
        while (octets_taken < OCTET_TARGET) begin
            msg_q.delete();
            len_pos.delete();
            n_attr = $urandom_range(1, 4);
            for (int a = 0; a < n_attr; a++) begin
                hdr = 8'($urandom_range(0, 255));
                // one maximum-length attribute; otherwise keep them short
                if (msg_count == 7 && a == 0) len = 8'hFF;
                else if ($urandom_range(0, 9) == 0) len = HEADER_OCTETS;
                else len = 8'($urandom_range(2, 17));
                msg_q.push_back(hdr);
                len_pos.push_back(msg_q.size());
                msg_q.push_back(len);
                repeat (int'(len - HEADER_OCTETS)) msg_q.push_back(8'($urandom_range(0, 255)));
                pad = (4 - len[1:0]) % 4;
                repeat (pad)
                    msg_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                : 8'h00);
            end
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // truncate anywhere
                cut = $urandom_range(0, msg_q.size() - 1);
                while (msg_q.size() > cut + 1) msg_q.pop_back();
            end else if (kind < 17) begin
                // short length on one of the attributes
                msg_q[len_pos[$urandom_range(0, len_pos.size() - 1)]] = 8'($urandom_range(0, 1));
            end else if (kind < 22) begin
                msg_q.delete();
                repeat ($urandom_range(1, 10)) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            send_message();
            msg_count++;
        end

        i_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        // let any stray result surface from the input and result registers
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Result side: check every accepted transaction, stall at random, and
    // once hold off for a long stretch so the pipeline fills and o_stall rises.
    initial begin : result_sink
        t_result     got;
        int unsigned hold_left;
        bit          pressure_done;

        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.emit          = 1'b1;
                got.attr_type     = o_attr_type;
                got.mandatory_bit = o_mandatory_bit;
                got.content_byte  = o_content_byte;
                got.content_valid = o_content_valid;
                got.attr_last     = o_attr_last;
                got.message_done  = o_message_done;
                got.malformed     = o_malformed;
                tracker.check_result(got);
                results_taken++;
            end
            if (hold_left != 0) begin
                hold_left--;
                hold_busy = (hold_left != 0);
                i_stall <= 1'b1;
            end else if (!pressure_done && results_taken >= HOLD_OFF_AT) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_OFF_LEN;
                hold_busy     = 1'b1;
                i_stall <= 1'b1;
            end else if (results_taken >= BURST_FROM && results_taken < BURST_TO) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Watchdog: any transaction on either side resets the count.
    initial begin : watchdog
        int unsigned quiet_cycles;

        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

endmodule
